[rtl/core/cmsg_pkg.sv]
// ----------------------------------------------------------------------------
// cmsg_pkg
// Shared constants, control word type and microcode ROM for the chaotic map
// section gate.
// ----------------------------------------------------------------------------
package cmsg_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int NUM_CHANNELS   = 8;
    localparam int MAX_ITERATIONS = 7;

    localparam int XW  = FRAC_BITS;          // map value
    localparam int GW  = FRAC_BITS + 2;      // gain, Q2.F, multiplier operand A
    localparam int BW  = FRAC_BITS + 1;      // multiplier operand B
    localparam int PW  = GW + BW;            // product
    localparam int CW  = $clog2(MAX_ITERATIONS + 1);
    localparam int PCW = 4;
    localparam int KW  = 2;                  // section exponent
    localparam int JW  = 3;                  // section index, up to 8 sections
    localparam int HW  = JW + $clog2(NUM_CHANNELS + 1) + 1;

    localparam logic [BW-1:0] ONE_B    = BW'(64'd1 << FRAC_BITS);
    localparam logic [BW-1:0] HALF_B   = BW'(64'd1 << (FRAC_BITS - 1));
    localparam logic [XW-1:0] FRAC_MAX = {XW{1'b1}};
    localparam logic [GW-1:0] LOG_BASE = GW'(64'd5 << (FRAC_BITS - 1));
    localparam logic [GW-1:0] LIN_BASE = GW'(64'd1 << FRAC_BITS);
    localparam logic [BW-1:0] LOG_SPAN = BW'(((64'd149 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [BW-1:0] LIN_SPAN = BW'(((64'd99 << FRAC_BITS) + 64'd50) / 64'd100);

    // register indexes
    localparam logic [1:0] REG_MAP_FUNCTION = 2'd0;
    localparam logic [1:0] REG_ITERATIONS   = 2'd1;
    localparam logic [1:0] REG_SECTION_EXP  = 2'd2;

    // map kinds
    localparam logic [1:0] MAP_LOGISTIC = 2'd0;
    localparam logic [1:0] MAP_TENT     = 2'd1;
    localparam logic [1:0] MAP_PARABOLA = 2'd2;

    // datapath operations
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_LDG = 2'd1;
    localparam logic [1:0] OP_LDX = 2'd2;
    localparam logic [1:0] OP_OUT = 2'd3;

    // operand A sources
    localparam logic [1:0] A_R  = 2'd0;
    localparam logic [1:0] A_G  = 2'd1;
    localparam logic [1:0] A_X  = 2'd2;
    localparam logic [1:0] A_PH = 2'd3;

    // operand B sources
    localparam logic [2:0] B_SPAN = 3'd0;
    localparam logic [2:0] B_OMX  = 3'd1;
    localparam logic [2:0] B_FOLD = 3'd2;
    localparam logic [2:0] B_DIST = 3'd3;
    localparam logic [2:0] B_PH   = 3'd4;

    // sequencing
    localparam logic [1:0] J_NEXT     = 2'd0;
    localparam logic [1:0] J_DISPATCH = 2'd1;
    localparam logic [1:0] J_LOOP     = 2'd2;
    localparam logic [1:0] J_END      = 2'd3;

    // program addresses
    localparam logic [PCW-1:0] S_GAIN_MUL = 4'd0;
    localparam logic [PCW-1:0] S_GAIN_LD  = 4'd1;
    localparam logic [PCW-1:0] S_LOG_0    = 4'd2;
    localparam logic [PCW-1:0] S_LOG_1    = 4'd3;
    localparam logic [PCW-1:0] S_LOG_2    = 4'd4;
    localparam logic [PCW-1:0] S_TENT_0   = 4'd5;
    localparam logic [PCW-1:0] S_TENT_1   = 4'd6;
    localparam logic [PCW-1:0] S_PAR_0    = 4'd7;
    localparam logic [PCW-1:0] S_PAR_1    = 4'd8;
    localparam logic [PCW-1:0] S_PAR_2    = 4'd9;
    localparam logic [PCW-1:0] S_FIN      = 4'd10;

    typedef struct packed {
        logic [1:0]     op;
        logic [1:0]     a_sel;
        logic [2:0]     b_sel;
        logic [1:0]     jmp;
        logic [PCW-1:0] target;
    } t_uop;

    function automatic t_uop uop_rom(input logic [PCW-1:0] pc);
        t_uop u;
        u = '{op: OP_OUT, a_sel: A_R, b_sel: B_SPAN, jmp: J_END, target: S_FIN};
        case (pc)
            S_GAIN_MUL: u = '{OP_MUL, A_R,  B_SPAN, J_NEXT,     S_GAIN_LD};
            S_GAIN_LD:  u = '{OP_LDG, A_R,  B_SPAN, J_DISPATCH, S_LOG_0};
            S_LOG_0:    u = '{OP_MUL, A_X,  B_OMX,  J_NEXT,     S_LOG_1};
            S_LOG_1:    u = '{OP_MUL, A_G,  B_PH,   J_NEXT,     S_LOG_2};
            S_LOG_2:    u = '{OP_LDX, A_R,  B_SPAN, J_LOOP,     S_LOG_0};
            S_TENT_0:   u = '{OP_MUL, A_G,  B_FOLD, J_NEXT,     S_TENT_1};
            S_TENT_1:   u = '{OP_LDX, A_R,  B_SPAN, J_LOOP,     S_TENT_0};
            S_PAR_0:    u = '{OP_MUL, A_G,  B_DIST, J_NEXT,     S_PAR_1};
            S_PAR_1:    u = '{OP_MUL, A_PH, B_PH,   J_NEXT,     S_PAR_2};
            S_PAR_2:    u = '{OP_LDX, A_R,  B_SPAN, J_LOOP,     S_PAR_0};
            S_FIN:      u = '{OP_OUT, A_R,  B_SPAN, J_END,      S_FIN};
            default:    u = '{OP_OUT, A_R,  B_SPAN, J_END,      S_FIN};
        endcase
        return u;
    endfunction

endpackage

[rtl/core/chaotic_map_section_gate_unit.sv]
// ----------------------------------------------------------------------------
// chaotic_map_section_gate_unit
// Iterated logistic / tent / parabola map with section gating of 1 - x.
// ----------------------------------------------------------------------------
// One input transfer carries the bifurcation control. A microcoded sequencer
// drives a single shared 18x17 multiplier: two steps form the gain, then each
// map application takes three steps (logistic, parabola) or two (tent), and
// one final step forms the result. The map is applied N times, N being the
// iteration count (1..7). The input stalls from the input transfer until
// the final step has formed the result, so a new item is not taken before
// the last one is through. The final step waits while an earlier result is
// still stalled. Once formed, the result waits in the output register until
// taken. A new input transfer is taken as soon as the sequencer is idle,
// also while a result is still waiting.
// ----------------------------------------------------------------------------
module chaotic_map_section_gate_unit
    import cmsg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [15:0]   i_bifurcation,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [15:0]   o_new_x,
    output logic [7:0]    o_active_mask,
    output logic [15:0]   o_section_cv,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [1:0]     r_map_function;
    logic [2:0]     r_iterations;
    logic [KW-1:0]  r_section_exp;

    logic           r_busy;
    logic [PCW-1:0] r_pc;
    logic [CW-1:0]  r_cnt;
    logic [15:0]    r_r;
    logic [GW-1:0]  r_g;
    logic [XW-1:0]  r_x;
    logic [PW-1:0]  r_p;

    logic           r_out_valid;
    logic [15:0]    r_new_x;
    logic [7:0]     r_mask;
    logic [15:0]    r_cv;

    t_uop           uop;
    logic           lin;
    logic           in_xfer;
    logic           out_hold;
    logic           out_load;
    logic           cfg_wr;
    logic [CW-1:0]  iter_clamped;
    logic [GW-1:0]  op_a;
    logic [BW-1:0]  op_b;
    logic [BW-1:0]  x_ext;
    logic [BW-1:0]  omx;
    logic [GW-1:0]  n_g;
    logic [XW-1:0]  n_x;
    logic [PCW-1:0] n_pc;
    logic [BW-1:0]  y;
    logic [JW-1:0]  sec_j;
    logic [HW-1:0]  lo;
    logic [HW-1:0]  hi;
    logic [NUM_CHANNELS-1:0] n_mask;
    logic [15:0]    n_cv;

    assign uop      = uop_rom(r_pc);
    assign lin      = r_map_function inside {MAP_TENT, MAP_PARABOLA};
    assign in_xfer  = i_valid && !r_busy;
    assign out_hold = r_out_valid && i_stall;
    assign out_load = r_busy && (uop.op == OP_OUT) && !out_hold;
    assign cfg_wr   = psel && penable && pwrite;

    assign o_stall       = r_busy;
    assign o_valid       = r_out_valid;
    assign o_new_x       = r_new_x;
    assign o_active_mask = r_mask;
    assign o_section_cv  = r_cv;
    assign pready        = 1'b1;

    always_comb begin
        prdata = 32'd0;
        case (paddr[3:2])
            REG_MAP_FUNCTION: prdata = {30'd0, r_map_function};
            REG_ITERATIONS:   prdata = {29'd0, r_iterations};
            REG_SECTION_EXP:  prdata = {{(32-KW){1'b0}}, r_section_exp};
            default:          prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_iterations == 3'd0) begin
            iter_clamped = CW'(1);
        end else if (CW'(r_iterations) > CW'(MAX_ITERATIONS)) begin
            iter_clamped = CW'(MAX_ITERATIONS);
        end else begin
            iter_clamped = CW'(r_iterations);
        end
    end

    // operand selection
    assign x_ext = BW'(r_x);
    assign omx   = ONE_B - x_ext;

    always_comb begin
        case (uop.a_sel)
            A_R:     op_a = GW'(r_r);
            A_G:     op_a = r_g;
            A_X:     op_a = GW'(r_x);
            A_PH:    op_a = r_p[FRAC_BITS +: GW];
            default: op_a = r_g;
        endcase
        case (uop.b_sel)
            B_SPAN:  op_b = lin ? LIN_SPAN : LOG_SPAN;
            B_OMX:   op_b = omx;
            B_FOLD:  op_b = (x_ext < HALF_B) ? x_ext : omx;
            B_DIST:  op_b = (x_ext >= HALF_B) ? (x_ext - HALF_B) : (HALF_B - x_ext);
            B_PH:    op_b = r_p[FRAC_BITS +: BW];
            default: op_b = omx;
        endcase
    end

    assign n_g = (lin ? LIN_BASE : LOG_BASE) + GW'(r_p[PW-1:FRAC_BITS]);
    assign n_x = (|r_p[PW-1:FRAC_BITS+XW]) ? FRAC_MAX : r_p[FRAC_BITS +: XW];

    always_comb begin
        case (uop.jmp)
            J_NEXT:     n_pc = uop.target;
            J_DISPATCH: begin
                case (r_map_function)
                    MAP_TENT:     n_pc = S_TENT_0;
                    MAP_PARABOLA: n_pc = S_PAR_0;
                    default:      n_pc = S_LOG_0;
                endcase
            end
            J_LOOP:     n_pc = (r_cnt > CW'(1)) ? uop.target : S_FIN;
            default:    n_pc = S_FIN;
        endcase
    end

    // section gating of y = 1 - x
    assign y     = omx;
    assign sec_j = JW'(y >> (FRAC_BITS - int'(r_section_exp)));
    assign lo    = HW'((HW'(sec_j) * HW'(NUM_CHANNELS)) >> r_section_exp);
    assign hi    = HW'(((HW'(sec_j) + HW'(1)) * HW'(NUM_CHANNELS)) >> r_section_exp);

    always_comb begin
        n_mask = '0;
        n_cv   = 16'd0;
        if (r_section_exp == KW'(0)) begin
            n_mask = '1;
            n_cv   = (y == ONE_B) ? FRAC_MAX : y[XW-1:0];
        end else if (y != ONE_B) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                n_mask[i] = (HW'(i) >= lo) && (HW'(i) < hi);
            end
            if (n_mask != '0) begin
                n_cv = XW'(y << r_section_exp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_function <= MAP_LOGISTIC;
            r_iterations   <= 3'd1;
            r_section_exp  <= KW'(3);
            r_busy         <= 1'b0;
            r_pc           <= S_GAIN_MUL;
            r_cnt          <= CW'(1);
            r_x            <= HALF_B[XW-1:0];
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_MAP_FUNCTION: r_map_function <= pwdata[1:0];
                    REG_ITERATIONS:   r_iterations   <= pwdata[2:0];
                    REG_SECTION_EXP:  r_section_exp  <= pwdata[KW-1:0];
                    default:          ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (in_xfer) begin
                r_busy <= 1'b1;
                r_pc   <= S_GAIN_MUL;
                r_cnt  <= iter_clamped;
                r_r    <= i_bifurcation;
            end else if (r_busy) begin
                case (uop.op)
                    OP_MUL: begin
                        r_p  <= PW'(op_a) * PW'(op_b);
                        r_pc <= n_pc;
                    end
                    OP_LDG: begin
                        r_g  <= n_g;
                        r_pc <= n_pc;
                    end
                    OP_LDX: begin
                        r_x  <= n_x;
                        r_pc <= n_pc;
                        if (r_cnt > CW'(1)) begin
                            r_cnt <= r_cnt - CW'(1);
                        end
                    end
                    default: begin
                        if (!out_hold) begin
                            r_new_x     <= r_x;
                            r_mask      <= 8'(n_mask);
                            r_cv        <= n_cv;
                            r_busy      <= 1'b0;
                            r_pc        <= S_GAIN_MUL;
                        end
                    end
                endcase
            end
        end
    end

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= S_FIN))
        else $error("sequencer left the program");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_busy && (r_pc == S_GAIN_MUL)))
        else $error("accepted transfer did not start the program");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("iteration counter ran out");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy && (r_pc == S_FIN)))
        else $error("result raised outside the final step");

endmodule

[tb/tb_chaotic_map_section_gate_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chaotic_map_section_gate_unit
// Self-checking bench for the chaotic map section gate.
// ----------------------------------------------------------------------------
// Configures map kind, iteration count and section count over the register
// port between phases, sends bifurcation controls through the valid/stall
// input and checks every result transfer against an in-bench model of the
// map iteration and section gating. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_chaotic_map_section_gate_unit;
    import cmsg_pkg::*;

    localparam logic [1:0] MAP_UNDEFINED = 2'd3;

    localparam longint unsigned FRAC_ONE           = 64'd1 << FRAC_BITS;
    localparam longint unsigned FRAC_HALF          = FRAC_ONE >> 1;
    localparam longint unsigned FRAC_TOP           = FRAC_ONE - 1;
    localparam longint unsigned LOGISTIC_GAIN_BASE = 64'd5 << (FRAC_BITS - 1);
    localparam longint unsigned LOGISTIC_GAIN_SPAN = ((64'd149 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam longint unsigned LINEAR_GAIN_SPAN   = ((64'd99 << FRAC_BITS) + 64'd50) / 64'd100;

    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 30;

    typedef struct {
        logic [15:0] new_x;
        logic [7:0]  active_mask;
        logic [15:0] section_cv;
    } t_gate_result;

    class t_section_gate_scoreboard;
        logic [15:0]  map_x;
        logic [1:0]   map_kind;
        logic [2:0]   iter_count;
        logic [1:0]   sect_exp;
        t_gate_result expected_gates[$];
        int           errors;
        int           zero_mask_seen;
        int           single_section_seen;

        function new();
            map_x = 16'(FRAC_HALF);
            map_kind = MAP_LOGISTIC;
            iter_count = 3'd1;
            sect_exp = 2'd3;
            errors = 0;
            zero_mask_seen = 0;
            single_section_seen = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_MAP_FUNCTION: map_kind = value[1:0];
                REG_ITERATIONS:   iter_count = value[2:0];
                REG_SECTION_EXP:  sect_exp = value[1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_gates.size();
        endfunction

        function logic [15:0] next_map_value(logic [15:0] x_in, longint unsigned gain);
            longint unsigned x, d, p, res;
            x = x_in;
            if (map_kind == MAP_TENT) begin
                res = (x < FRAC_HALF) ? (gain * x) >> FRAC_BITS
                                      : (gain * (FRAC_ONE - x)) >> FRAC_BITS;
            end else if (map_kind == MAP_PARABOLA) begin
                d = (x >= FRAC_HALF) ? x - FRAC_HALF : FRAC_HALF - x;
                p = (gain * d) >> FRAC_BITS;
                res = (p * p) >> FRAC_BITS;
            end else begin
                p = (x * (FRAC_ONE - x)) >> FRAC_BITS;
                res = (gain * p) >> FRAC_BITS;
            end
            if (res > FRAC_TOP)
                res = FRAC_TOP;
            return res[15:0];
        endfunction

        function void note_transfer(logic [15:0] bifurcation);
            longint unsigned r, gain, y, j, lo, hi;
            int steps;
            t_gate_result e;
            r = bifurcation;
            if (map_kind inside {MAP_TENT, MAP_PARABOLA})
                gain = FRAC_ONE + ((r * LINEAR_GAIN_SPAN) >> FRAC_BITS);
            else
                gain = LOGISTIC_GAIN_BASE + ((r * LOGISTIC_GAIN_SPAN) >> FRAC_BITS);
            steps = (iter_count == 0) ? 1 : int'(iter_count);
            for (int i = 0; i < steps; i++)
                map_x = next_map_value(map_x, gain);

            e.new_x = map_x;
            e.active_mask = 8'h00;
            e.section_cv = 16'h0000;
            y = FRAC_ONE - longint'(map_x);
            if (sect_exp == 0) begin
                e.active_mask = 8'hFF;
                e.section_cv = (y > FRAC_TOP) ? 16'(FRAC_TOP) : 16'(y);
                single_section_seen++;
            end else if (y < FRAC_ONE) begin
                j = y >> (FRAC_BITS - sect_exp);
                lo = (j * NUM_CHANNELS) >> sect_exp;
                hi = ((j + 1) * NUM_CHANNELS) >> sect_exp;
                for (int i = int'(lo); i < int'(hi) && i < NUM_CHANNELS; i++)
                    e.active_mask[i] = 1'b1;
                if (e.active_mask != 0)
                    e.section_cv = 16'((y << sect_exp) & FRAC_TOP);
            end
            if (e.active_mask == 0)
                zero_mask_seen++;
            expected_gates.push_back(e);
        endfunction

        function void check_result(logic [15:0] new_x, logic [7:0] mask, logic [15:0] cv);
            t_gate_result e;
            if (expected_gates.size() == 0) begin
                $display("%0t: unexpected result x=%h mask=%h cv=%h", $time, new_x, mask, cv);
                errors++;
                return;
            end
            e = expected_gates.pop_front();
            if (new_x !== e.new_x) begin
                $display("%0t: new_x expected %h got %h", $time, e.new_x, new_x);
                errors++;
            end
            if (mask !== e.active_mask) begin
                $display("%0t: active_mask expected %h got %h", $time, e.active_mask, mask);
                errors++;
            end
            if (cv !== e.section_cv) begin
                $display("%0t: section_cv expected %h got %h", $time, e.section_cv, cv);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_bifurcation = 16'h0000;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_new_x;
    logic [7:0]  o_active_mask;
    logic [15:0] o_section_cv;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    t_section_gate_scoreboard sb;
    int tx_mode = 1;
    int rx_mode = 1;
    int stall_left = 0;
    int quiet_cycles = 0;
    int phases = 0;

    chaotic_map_section_gate_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_bifurcation (i_bifurcation),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_new_x       (o_new_x),
        .o_active_mask (o_active_mask),
        .o_section_cv  (o_section_cv),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // mostly short idle stretches, the odd long one
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 2);
        else if (pick < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_control();
        logic [15:0] bit_sel;
        bit_sel = 16'h0001 << $urandom_range(0, 15);
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return bit_sel;
            3: return ~bit_sel;
            default: return 16'($urandom);
        endcase
    endfunction

    // transfer monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_transfer(i_bifurcation);
            if (o_valid && !i_stall)
                sb.check_result(o_new_x, o_active_mask, o_section_cv);
        end
    end

    // result-side back-pressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (rx_mode != 0 && $urandom_range(0, 99) < (rx_mode == 2 ? 40 : 15)) begin
            i_stall <= 1'b1;
            stall_left <= idle_length() - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [1:0] kind, input logic [2:0] iters,
                                  input logic [1:0] sexp);
        drain();
        reg_write(REG_MAP_FUNCTION, {30'd0, kind});
        reg_write(REG_ITERATIONS, {29'd0, iters});
        reg_write(REG_SECTION_EXP, {30'd0, sexp});
        phases++;
    endtask

    task automatic send_item(input logic [15:0] control);
        int gap;
        gap = 0;
        if (tx_mode != 0 && $urandom_range(0, 99) < (tx_mode == 2 ? 50 : 20))
            gap = idle_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_bifurcation <= control;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin
        int sent;
        int count;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // half maps to zero under the parabola, so y is one and the mask is empty
        apply_settings(MAP_PARABOLA, 3'd1, 2'd3);
        send_item(16'h0000);
        // zero is a fixed point of the logistic map: single section with y at one
        apply_settings(MAP_LOGISTIC, 3'd1, 2'd0);
        send_item(16'hFFFF);
        send_item(16'h0000);
        apply_settings(MAP_PARABOLA, 3'd7, 2'd1);
        send_item(16'hFFFF);
        send_item(16'h0000);
        send_item(16'h8000);
        // zero iterations acts as one
        apply_settings(MAP_TENT, 3'd0, 2'd2);
        send_item(16'h0000);
        send_item(16'hFFFF);
        send_item(16'h5555);
        send_item(16'hAAAA);
        // unused map code falls back to logistic
        apply_settings(MAP_UNDEFINED, 3'd3, 2'd3);
        send_item(16'hFFFF);
        send_item(16'h0001);
        send_item(16'hFFFE);
        send_item(16'h7FFF);
        apply_settings(MAP_LOGISTIC, 3'd7, 2'd0);
        send_item(16'h8000);
        send_item(16'hFFFF);
        apply_settings(MAP_TENT, 3'd7, 2'd3);
        send_item(16'hFFFF);
        send_item(16'h0000);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            apply_settings(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                           2'($urandom_range(0, 3)));
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);
            count = $urandom_range(15, 50);
            repeat (count) begin
                send_item(pick_control());
                if ($urandom_range(0, 99) < 3)
                    drain();
            end
            sent += count;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("covered %0d settings of map kind, iteration count and section count",
                 phases);
        $display("gating: %0d results with empty mask, %0d with a single section",
                 sb.zero_mask_seen, sb.single_section_seen);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
